FILE: sv/fpw_pkg.sv
// fpw_pkg: shared constants, codes and divider handshake types for the
// framebuffer pixel writeback block. No dependencies.
`default_nettype none

package fpw_pkg;

   // default video memory size in bytes
   localparam int unsigned MEMORY_BYTES_DEF = 131072;

   localparam int unsigned ADDR_W     = 17;
   localparam int unsigned PIX_ADDR_W = 18;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CFG_W      = 11;
   localparam int unsigned COORD_W    = 10;
   localparam int unsigned WH_W       = 21;
   localparam int unsigned VIS_W      = 22;

   // stream and register port widths
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CFG_W-1:0] DIM_MAX       = 11'd1024;
   localparam logic [CFG_W-1:0] WIDTH_RESET   = 11'd200;
   localparam logic [CFG_W-1:0] HEIGHT_RESET  = 11'd150;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 2'd2;

   // color modes, the unused code behaves as rgb888
   localparam logic [1:0] MODE_RGB888 = 2'd0;
   localparam logic [1:0] MODE_RGB565 = 2'd1;
   localparam logic [1:0] MODE_MONO   = 2'd2;

   // access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // bytes per pixel codes
   localparam logic [1:0] BPP_ONE   = 2'd1;
   localparam logic [1:0] BPP_TWO   = 2'd2;
   localparam logic [1:0] BPP_THREE = 2'd3;

   // divide by three as multiply by ceil(2^17/3) and shift
   localparam int unsigned     DIV3_SHIFT = 17;
   localparam logic [15:0]     DIV3_RECIP = 16'd43691;
   localparam int unsigned     PROD_W     = ADDR_W + 16;

   // iterative divider: pixel index by screen width, radix 16
   localparam int unsigned DIV_N_W     = ADDR_W;
   localparam int unsigned DIV_D_W     = CFG_W;
   localparam int unsigned DIV_RADIX   = 4;
   localparam int unsigned DIV_ITERS   = (DIV_N_W + DIV_RADIX - 1) / DIV_RADIX;
   localparam int unsigned DIV_PAD_W   = DIV_ITERS * DIV_RADIX;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_ITERS);

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic [DIV_N_W-1:0] quot;
      logic [DIV_D_W-1:0] rem;
   } div_rsp_type;

   function automatic logic [1:0] bytes_per_pixel(input logic [1:0] mode);
      logic [1:0] bpp;
      unique case (mode)
         MODE_RGB565: bpp = BPP_TWO;
         MODE_MONO:   bpp = BPP_ONE;
         default:     bpp = BPP_THREE;
      endcase
      return bpp;
   endfunction

endpackage

`default_nettype wire

FILE: sv/fpw_vram.sv
// fpw_vram: single-port byte video memory, one access per cycle,
// read data registered. Depends on fpw_pkg for the byte width and default depth.
`default_nettype none

module fpw_vram #(
   parameter int unsigned DEPTH = fpw_pkg::MEMORY_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic                          we,
   input  wire logic [$clog2(DEPTH)-1:0]      addr,
   input  wire logic [fpw_pkg::BYTE_W-1:0]    wdata,
   output      logic [fpw_pkg::BYTE_W-1:0]    rdata
);

   logic [fpw_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [fpw_pkg::BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/fpw_div.sv
// fpw_div: iterative unsigned divider, four quotient bits per cycle,
// splits a pixel index into row and column. Depends on fpw_pkg.
`default_nettype none

module fpw_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpw_pkg::div_req_type req,
   output      fpw_pkg::div_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic [fpw_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [fpw_pkg::DIV_PAD_W-1:0]     num_ff, num_in;
   logic [fpw_pkg::DIV_D_W-1:0]       rem_ff, rem_in;
   logic [fpw_pkg::DIV_D_W-1:0]       dsr_ff, dsr_in;
   logic [fpw_pkg::DIV_PAD_W-1:0]     step_num;
   logic [fpw_pkg::DIV_D_W-1:0]       step_rem;

   // four restoring steps; numerator shifts out msb first, quotient bits shift in
   always_comb begin
      logic [fpw_pkg::DIV_D_W-1:0]   r;
      logic [fpw_pkg::DIV_D_W-1:0]   t;
      logic [fpw_pkg::DIV_PAD_W-1:0] n;
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < fpw_pkg::DIV_RADIX; i++) begin
         t = {r[fpw_pkg::DIV_D_W-2:0], n[fpw_pkg::DIV_PAD_W-1]};
         n = {n[fpw_pkg::DIV_PAD_W-2:0], 1'b0};
         if (t >= dsr_ff) begin
            r    = t - dsr_ff;
            n[0] = 1'b1;
         end else begin
            r = t;
         end
      end
      step_num = n;
      step_rem = r;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = fpw_pkg::DIV_PAD_W'(req.dividend);
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = step_num;
         rem_in = step_rem;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fpw_pkg::DIV_CNT_W'(fpw_pkg::DIV_ITERS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.quot = num_ff[fpw_pkg::DIV_N_W-1:0];
   assign rsp.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: sv/framebuffer_pixel_writeback.sv
// framebuffer_pixel_writeback: byte video memory with pixel read-back on writes.
// Depends on fpw_pkg, fpw_vram (byte memory) and fpw_div (row/column divider).
//
//   channel  direction  handshake                  payload
//   req      in         req_tvalid / req_tready    req_tdata, req_tuser
//   rsp      out        rsp_tvalid / rsp_tready    rsp_tdata, rsp_tuser
//   csr      in         csr_valid / csr_ready      csr_index, csr_data
//
// A read or an off-screen write goes through the access and index states to the
// result, an on-screen write also through S_RD0 to S_RD3 and S_WAIT: the single
// memory port serves the write and three pixel reads one per cycle, while the
// radix-16 divider runs five iterations. After reset the memory is cleared one
// byte per cycle with req_tready low; register writes are taken at any time.
// A result waiting on rsp_tready does not stop the next request transfer.
`default_nettype none

module framebuffer_pixel_writeback #(
   parameter int unsigned MEMORY_BYTES = fpw_pkg::MEMORY_BYTES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [16:0] address, [24:17] write_byte, rest zero
   input  wire logic [fpw_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] kind
   input  wire logic                                req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] read_byte, [17:8] pixel_x, [27:18] pixel_y, [35:28] red,
   // [43:36] green, [51:44] blue, rest zero
   output      logic [fpw_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] pixel_valid
   output      logic                                rsp_tuser,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [fpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fpw_pkg::CFG_W-1:0]           csr_data
);

   localparam int unsigned AW = $clog2(MEMORY_BYTES);
   localparam int unsigned CW =
      ((AW > fpw_pkg::PIX_ADDR_W) ? AW : fpw_pkg::PIX_ADDR_W) + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ACCESS, S_INDEX,
      S_RD0, S_RD1, S_RD2, S_RD3, S_WAIT, S_DONE
   } state_type;

   function automatic logic fits_mem(input logic [fpw_pkg::PIX_ADDR_W-1:0] a);
      return CW'(a) < CW'(MEMORY_BYTES);
   endfunction

   state_type                              state_ff, state_in;
   logic [AW-1:0]                          clr_cnt_ff, clr_cnt_in;
   logic [fpw_pkg::CFG_W-1:0]              width_ff, width_in;
   logic [fpw_pkg::CFG_W-1:0]              height_ff, height_in;
   logic [1:0]                             mode_ff, mode_in;
   logic                                   kind_ff, kind_in;
   logic [fpw_pkg::ADDR_W-1:0]             addr_ff, addr_in;
   logic [fpw_pkg::BYTE_W-1:0]             wbyte_ff, wbyte_in;
   logic                                   in_mem_ff, in_mem_in;
   logic [fpw_pkg::PROD_W-1:0]             prod_ff, prod_in;
   logic [fpw_pkg::WH_W-1:0]               wh_ff, wh_in;
   logic [fpw_pkg::PIX_ADDR_W-1:0]         base_ff, base_in;
   logic                                   visible_ff, visible_in;
   logic [fpw_pkg::BYTE_W-1:0]             rbyte_ff, rbyte_in;
   logic [fpw_pkg::BYTE_W-1:0]             b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic                                   rd_ok_ff, rd_ok_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [fpw_pkg::BYTE_W-1:0]             rsp_rbyte_ff, rsp_rbyte_in;
   logic                                   rsp_pv_ff, rsp_pv_in;
   logic [fpw_pkg::COORD_W-1:0]            rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [fpw_pkg::BYTE_W-1:0]             rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in;
   logic [fpw_pkg::BYTE_W-1:0]             rsp_b_ff, rsp_b_in;

   logic                                   mem_en, mem_we;
   logic [AW-1:0]                          mem_addr;
   logic [fpw_pkg::BYTE_W-1:0]             mem_wdata, mem_rdata;
   fpw_pkg::div_req_type                   div_req;
   fpw_pkg::div_rsp_type                   div_rsp;

   logic [fpw_pkg::CFG_W-1:0]              w_sat, h_sat;
   logic [1:0]                             bpp;
   logic [2*fpw_pkg::CFG_W-1:0]            wh_full;
   logic [fpw_pkg::ADDR_W-1:0]             idx_sel;
   logic [fpw_pkg::PIX_ADDR_W-1:0]         base_sel;
   logic [fpw_pkg::VIS_W-1:0]              vis;
   logic                                   visible_now;
   logic [fpw_pkg::PIX_ADDR_W-1:0]         rd_addr;
   logic [1:0]                             rd_off;
   logic [2*fpw_pkg::BYTE_W-1:0]           word565;

   assign w_sat   = (width_ff > fpw_pkg::DIM_MAX) ? fpw_pkg::DIM_MAX : width_ff;
   assign h_sat   = (height_ff > fpw_pkg::DIM_MAX) ? fpw_pkg::DIM_MAX : height_ff;
   assign bpp     = fpw_pkg::bytes_per_pixel(mode_ff);
   assign wh_full = (2*fpw_pkg::CFG_W)'(w_sat) * (2*fpw_pkg::CFG_W)'(h_sat);
   assign word565 = {b1_ff, b0_ff};

   // pixel index, its first byte and the visible size in bytes
   always_comb begin
      unique case (bpp)
         fpw_pkg::BPP_THREE: begin
            idx_sel  = fpw_pkg::ADDR_W'(prod_ff[fpw_pkg::PROD_W-1:fpw_pkg::DIV3_SHIFT]);
            base_sel = fpw_pkg::PIX_ADDR_W'({idx_sel, 1'b0}) +
                       fpw_pkg::PIX_ADDR_W'(idx_sel);
            vis      = fpw_pkg::VIS_W'({wh_ff, 1'b0}) + fpw_pkg::VIS_W'(wh_ff);
         end
         fpw_pkg::BPP_TWO: begin
            idx_sel  = addr_ff >> 1;
            base_sel = fpw_pkg::PIX_ADDR_W'({addr_ff[fpw_pkg::ADDR_W-1:1], 1'b0});
            vis      = fpw_pkg::VIS_W'({wh_ff, 1'b0});
         end
         default: begin
            idx_sel  = addr_ff;
            base_sel = fpw_pkg::PIX_ADDR_W'(addr_ff);
            vis      = fpw_pkg::VIS_W'(wh_ff);
         end
      endcase
   end

   assign visible_now = (kind_ff == fpw_pkg::KIND_WRITE) && in_mem_ff &&
                        (w_sat != '0) && (fpw_pkg::VIS_W'(addr_ff) < vis);

   always_comb begin
      unique case (state_ff)
         S_RD1:   rd_off = 2'd1;
         S_RD2:   rd_off = 2'd2;
         default: rd_off = 2'd0;
      endcase
   end
   assign rd_addr = base_ff + fpw_pkg::PIX_ADDR_W'(rd_off);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      wbyte_in     = wbyte_ff;
      in_mem_in    = in_mem_ff;
      prod_in      = prod_ff;
      wh_in        = wh_ff;
      base_in      = base_ff;
      visible_in   = visible_ff;
      rbyte_in     = rbyte_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rbyte_in = rsp_rbyte_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = '0;
      div_req      = '0;

      if (csr_valid) begin
         unique case (csr_index)
            fpw_pkg::CSR_WIDTH:  width_in  = csr_data;
            fpw_pkg::CSR_HEIGHT: height_in = csr_data;
            fpw_pkg::CSR_MODE:   mode_in   = csr_data[1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(MEMORY_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               addr_in   = req_tdata[fpw_pkg::ADDR_W-1:0];
               wbyte_in  = req_tdata[fpw_pkg::ADDR_W +: fpw_pkg::BYTE_W];
               in_mem_in = fits_mem(fpw_pkg::PIX_ADDR_W'(req_tdata[fpw_pkg::ADDR_W-1:0]));
               state_in  = S_ACCESS;
            end
         end
         S_ACCESS: begin
            // a write inside the memory stores the byte, a read fetches it
            mem_en    = in_mem_ff;
            mem_we    = (kind_ff == fpw_pkg::KIND_WRITE);
            mem_addr  = AW'(addr_ff);
            mem_wdata = wbyte_ff;
            prod_in   = fpw_pkg::PROD_W'(addr_ff) * fpw_pkg::PROD_W'(fpw_pkg::DIV3_RECIP);
            wh_in     = wh_full[fpw_pkg::WH_W-1:0];
            state_in  = S_INDEX;
         end
         S_INDEX: begin
            base_in    = base_sel;
            visible_in = visible_now;
            if (!in_mem_ff) begin
               rbyte_in = '0;
            end else if (kind_ff == fpw_pkg::KIND_WRITE) begin
               rbyte_in = wbyte_ff;
            end else begin
               rbyte_in = mem_rdata;
            end
            div_req.start    = visible_now;
            div_req.dividend = idx_sel;
            div_req.divisor  = w_sat;
            state_in = visible_now ? S_RD0 : S_DONE;
         end
         S_RD0, S_RD1, S_RD2: begin
            // pixel bytes past the memory read as zero
            rd_ok_in = fits_mem(rd_addr);
            mem_en   = rd_ok_in;
            mem_addr = AW'(rd_addr);
            if (state_ff == S_RD1) begin
               b0_in = rd_ok_ff ? mem_rdata : '0;
            end
            if (state_ff == S_RD2) begin
               b1_in = rd_ok_ff ? mem_rdata : '0;
            end
            unique case (state_ff)
               S_RD0:   state_in = S_RD1;
               S_RD1:   state_in = S_RD2;
               default: state_in = S_RD3;
            endcase
         end
         S_RD3: begin
            b2_in    = rd_ok_ff ? mem_rdata : '0;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (!div_rsp.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rbyte_in = rbyte_ff;
               rsp_pv_in    = visible_ff;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_r_in     = '0;
               rsp_g_in     = '0;
               rsp_b_in     = '0;
               if (visible_ff) begin
                  rsp_x_in = div_rsp.rem[fpw_pkg::COORD_W-1:0];
                  rsp_y_in = div_rsp.quot[fpw_pkg::COORD_W-1:0];
                  unique case (bpp)
                     fpw_pkg::BPP_THREE: begin
                        rsp_r_in = b0_ff;
                        rsp_g_in = b1_ff;
                        rsp_b_in = b2_ff;
                     end
                     fpw_pkg::BPP_TWO: begin
                        rsp_r_in = {word565[15:11], 3'b000};
                        rsp_g_in = {word565[10:5], 2'b00};
                        rsp_b_in = {word565[4:0], 3'b000};
                     end
                     default: begin
                        rsp_r_in = b0_ff;
                        rsp_g_in = b0_ff;
                        rsp_b_in = b0_ff;
                     end
                  endcase
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         width_ff     <= fpw_pkg::WIDTH_RESET;
         height_ff    <= fpw_pkg::HEIGHT_RESET;
         mode_ff      <= fpw_pkg::MODE_RGB888;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      addr_ff      <= addr_in;
      wbyte_ff     <= wbyte_in;
      in_mem_ff    <= in_mem_in;
      prod_ff      <= prod_in;
      wh_ff        <= wh_in;
      base_ff      <= base_in;
      visible_ff   <= visible_in;
      rbyte_ff     <= rbyte_in;
      b0_ff        <= b0_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_rbyte_ff <= rsp_rbyte_in;
      rsp_pv_ff    <= rsp_pv_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_g_ff     <= rsp_g_in;
      rsp_b_ff     <= rsp_b_in;
   end

   fpw_vram #(
      .DEPTH (MEMORY_BYTES)
   ) u_vram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   fpw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tdata  = {4'b0000, rsp_b_ff, rsp_g_ff, rsp_r_ff,
                        rsp_y_ff, rsp_x_ff, rsp_rbyte_ff};

   // no request transfer while the memory is being cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request taken during clear");

   // the memory is only written by the clear sweep or the access step
   assert property (@(posedge clock) disable iff (reset)
      (mem_en && mem_we) |-> (state_ff == S_CLEAR || state_ff == S_ACCESS))
      else $error("memory write outside clear or access");

   // a request transfer always starts the memory access next
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_ACCESS))
      else $error("transfer not followed by access");

   // the result never samples a divider still at work
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && visible_ff) |-> !div_rsp.busy)
      else $error("row and column taken from busy divider");

   // without a pixel the pixel fields stay zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pv_ff) |->
         (rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_r_ff == '0 &&
          rsp_g_ff == '0 && rsp_b_ff == '0))
      else $error("pixel fields set without a pixel");

endmodule

`default_nettype wire
